// ===== src/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

	typedef logic [1:0] kind_t;
	localparam kind_t OP_ADD = 2'd0;
	localparam kind_t OP_SUB = 2'd1;
	localparam kind_t OP_MUL = 2'd2;
	localparam kind_t OP_DIV = 2'd3;

	typedef logic [1:0] stat_t;
	localparam stat_t ST_OK   = 2'd0;
	localparam stat_t ST_DIV0 = 2'd1;
	localparam stat_t ST_SAT  = 2'd2;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

endpackage

// ===== src/cau_front.sv =====
// Front stages: products, sums, add/sub/mul results and divide operands.
`timescale 1ns / 1ps
module cau_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cau_pkg::ctl_t         in_ctl,
	input  logic [31:0]           a_re,
	input  logic [31:0]           a_im,
	input  logic [31:0]           b_re,
	input  logic [31:0]           b_im,
	output cau_pkg::ctl_t         out_ctl,
	output logic signed [W-1:0]   fix_re,
	output logic signed [W-1:0]   fix_im,
	output logic                  fix_sat,
	output logic                  nneg_re,
	output logic [2*W:0]          nmag_re,
	output logic                  nneg_im,
	output logic [2*W:0]          nmag_im,
	output logic [2*W-1:0]        den,
	output logic                  dzero
);

	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;

	// {overflow flag, clamped value}
	function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
		logic hi_all1;
		logic hi_all0;
		hi_all1 = &v[SW-1:W-1];
		hi_all0 = ~|v[SW-1:W-1];
		if (hi_all1 || hi_all0)
			sat_w = {1'b0, v[W-1:0]};
		else if (v[SW-1])
			sat_w = {1'b1, 1'b1, {(W-1){1'b0}}};
		else
			sat_w = {1'b1, 1'b0, {(W-1){1'b1}}};
	endfunction

	logic signed [W-1:0] ar, ai, br, bi;
	logic signed [W:0]   as_re, as_im;

	assign ar = $signed(a_re[W-1:0]);
	assign ai = $signed(a_im[W-1:0]);
	assign br = $signed(b_re[W-1:0]);
	assign bi = $signed(b_im[W-1:0]);

	always_comb begin
		if (in_ctl.kind == cau_pkg::OP_SUB) begin
			as_re = (W+1)'(ar) - (W+1)'(br);
			as_im = (W+1)'(ai) - (W+1)'(bi);
		end else begin
			as_re = (W+1)'(ar) + (W+1)'(br);
			as_im = (W+1)'(ai) + (W+1)'(bi);
		end
	end

	cau_pkg::ctl_t        ctl_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, sq_r_s1, sq_i_s1;
	logic signed [W:0]    as_re_s1, as_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1  <= PW'(ar) * PW'(br);
		p_ii_s1  <= PW'(ai) * PW'(bi);
		p_ir_s1  <= PW'(ai) * PW'(br);
		p_ri_s1  <= PW'(ar) * PW'(bi);
		sq_r_s1  <= PW'(br) * PW'(br);
		sq_i_s1  <= PW'(bi) * PW'(bi);
		as_re_s1 <= as_re;
		as_im_s1 <= as_im;
	end

	logic signed [SW-1:0] m_re, m_im, d_re, d_im;
	logic [W:0]           sm_re, sm_im, sa_re, sa_im;
	logic [PW-1:0]        den_c;

	always_comb begin
		m_re  = (SW'(p_rr_s1) - SW'(p_ii_s1)) >>> F;
		m_im  = (SW'(p_ir_s1) + SW'(p_ri_s1)) >>> F;
		d_re  = SW'(p_rr_s1) + SW'(p_ii_s1);
		d_im  = SW'(p_ir_s1) - SW'(p_ri_s1);
		sm_re = sat_w(m_re);
		sm_im = sat_w(m_im);
		sa_re = sat_w(SW'(as_re_s1));
		sa_im = sat_w(SW'(as_im_s1));
		den_c = $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else begin
			out_ctl <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.kind == cau_pkg::OP_MUL) begin
			fix_re  <= $signed(sm_re[W-1:0]);
			fix_im  <= $signed(sm_im[W-1:0]);
			fix_sat <= sm_re[W] | sm_im[W];
		end else begin
			fix_re  <= $signed(sa_re[W-1:0]);
			fix_im  <= $signed(sa_im[W-1:0]);
			fix_sat <= sa_re[W] | sa_im[W];
		end
		nneg_re <= d_re[SW-1];
		nmag_re <= d_re[SW-1] ? $unsigned(-d_re) : $unsigned(d_re);
		nneg_im <= d_im[SW-1];
		nmag_im <= d_im[SW-1] ? $unsigned(-d_im) : $unsigned(d_im);
		den     <= den_c;
		dzero   <= (den_c == '0);
	end

endmodule

// ===== src/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module cau_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic           clk,
	input  logic           neg_in,
	input  logic [2*W:0]   mag_in,
	input  logic [2*W-1:0] den_in,
	output logic [W-1:0]   q,
	output logic           ovf,
	output logic           neg
);

	localparam int PW = 2 * W;
	localparam int RW = 3 * W + F + 1;

	logic [RW-1:0] rem_s [0:W];
	logic [PW-1:0] den_s [0:W];
	logic [W-1:0]  q_s   [0:W];
	logic          ovf_s [0:W];
	logic          neg_s [0:W];

	logic [RW-1:0] num0;
	assign num0 = RW'(mag_in) << F;

	// quotient of more than W bits always saturates
	always_ff @(posedge clk) begin
		rem_s[0] <= num0;
		den_s[0] <= den_in;
		q_s[0]   <= '0;
		ovf_s[0] <= num0 >= (RW'(den_in) << W);
		neg_s[0] <= neg_in;
	end

	for (genvar k = 0; k < W; k++) begin : g_stage
		localparam int B = W - 1 - k;
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = RW'(den_s[k]) << B;
		assign ge    = rem_s[k] >= trial;
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
			den_s[k+1] <= den_s[k];
			q_s[k+1]   <= q_s[k] | (W'(ge) << B);
			ovf_s[k+1] <= ovf_s[k];
			neg_s[k+1] <= neg_s[k];
		end
	end

	assign q   = q_s[W];
	assign ovf = ovf_s[W];
	assign neg = neg_s[W];

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Top level: complex add, subtract, multiply and divide in signed fixed point.
// Every kind takes the same path from the start transfer to done: front stages, delay line, output register.
// Throughput: one item per cycle; busy is always low, the divider pipeline
// (one quotient bit per stage) sets the depth.
// Reset clears the stage valid bits; no result is in flight after reset.
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        done,
	output logic [31:0] r_re,
	output logic [31:0] r_im,
	output logic [1:0]  status
);

	localparam int W   = DATA_WIDTH;
	localparam int D   = W + 1;
	localparam int LAT = W + 4;
	localparam logic [W-1:0] HALF = W'(1) << (W - 1);

	assign busy = 1'b0;

	cau_pkg::ctl_t       in_ctl, f_ctl;
	logic signed [W-1:0] f_re, f_im;
	logic                f_sat, nneg_re, nneg_im, dzero;
	logic [2*W:0]        nmag_re, nmag_im;
	logic [2*W-1:0]      den;

	assign in_ctl.valid = start & ~busy;
	assign in_ctl.kind  = kind;

	cau_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ctl(in_ctl),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_ctl(f_ctl), .fix_re(f_re), .fix_im(f_im), .fix_sat(f_sat),
		.nneg_re(nneg_re), .nmag_re(nmag_re), .nneg_im(nneg_im), .nmag_im(nmag_im),
		.den(den), .dzero(dzero)
	);

	logic [W-1:0] q_re, q_im;
	logic         ovf_re, ovf_im, neg_re, neg_im;

	cau_div #(.W(W), .F(FRAC_BITS)) u_div_re (
		.clk(clk), .neg_in(nneg_re), .mag_in(nmag_re), .den_in(den),
		.q(q_re), .ovf(ovf_re), .neg(neg_re)
	);

	cau_div #(.W(W), .F(FRAC_BITS)) u_div_im (
		.clk(clk), .neg_in(nneg_im), .mag_in(nmag_im), .den_in(den),
		.q(q_im), .ovf(ovf_im), .neg(neg_im)
	);

	// side data travels alongside the divider stages
	cau_pkg::ctl_t       ctl_s [0:D];
	logic signed [W-1:0] fre_s [0:D];
	logic signed [W-1:0] fim_s [0:D];
	logic                fsat_s [0:D];
	logic                dz_s [0:D];

	assign ctl_s[0]  = f_ctl;
	assign fre_s[0]  = f_re;
	assign fim_s[0]  = f_im;
	assign fsat_s[0] = f_sat;
	assign dz_s[0]   = dzero;

	for (genvar k = 0; k < D; k++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end
		always_ff @(posedge clk) begin
			fre_s[k+1]  <= fre_s[k];
			fim_s[k+1]  <= fim_s[k];
			fsat_s[k+1] <= fsat_s[k];
			dz_s[k+1]   <= dz_s[k];
		end
	end

	// {saturated, value} for one quotient part
	function automatic logic [W:0] clamp_q(input logic o, input logic n,
	                                       input logic [W-1:0] qv);
		if (o || (n ? (qv > HALF) : (qv > HALF - W'(1))))
			clamp_q = n ? {1'b1, HALF} : {1'b1, HALF - W'(1)};
		else
			clamp_q = {1'b0, n ? W'(-qv) : qv};
	endfunction

	logic [W:0]          c_re, c_im;
	logic signed [W-1:0] o_re, o_im;
	cau_pkg::stat_t      o_st;

	always_comb begin
		c_re = clamp_q(ovf_re, neg_re, q_re);
		c_im = clamp_q(ovf_im, neg_im, q_im);
		if (ctl_s[D].kind == cau_pkg::OP_DIV) begin
			if (dz_s[D]) begin
				o_re = '0;
				o_im = '0;
				o_st = cau_pkg::ST_DIV0;
			end else begin
				o_re = $signed(c_re[W-1:0]);
				o_im = $signed(c_im[W-1:0]);
				o_st = (c_re[W] | c_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end else begin
			o_re = fre_s[D];
			o_im = fim_s[D];
			o_st = fsat_s[D] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	logic                done_q;
	logic signed [W-1:0] r_re_q, r_im_q;
	cau_pkg::stat_t      status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[D].valid;
		end
	end

	always_ff @(posedge clk) begin
		r_re_q   <= o_re;
		r_im_q   <= o_im;
		status_q <= o_st;
	end

	assign done   = done_q;
	assign r_re   = 32'(r_re_q);
	assign r_im   = 32'(r_im_q);
	assign status = status_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result transfer missing after start");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cau_pkg::ST_DIV0) |-> (r_re == 32'd0 && r_im == 32'd0))
		else $error("division by zero with nonzero result");

	a_div0_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[D].valid && ctl_s[D].kind != cau_pkg::OP_DIV) |=> (status != cau_pkg::ST_DIV0))
		else $error("division by zero status on a non-divide");

endmodule
